FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the drum sequencer.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

FILE: hdl/dsm_pkg.sv
// Package of the drum step sequencer mixer: constants, register map, types.
// No dependencies.
package dsm_pkg;

  localparam int unsigned SAMPLE_DEPTH = 8192;
  localparam int unsigned STEP_COUNT   = 16;
  localparam int unsigned VOICE_COUNT  = 3;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned STEP_W   = 4;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned LEN_W    = 14;
  localparam int unsigned ADDR_IN_W = 13;
  localparam int unsigned VOICE_W  = 2;
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned CNT_W    = 2;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE    = 12'd4095;
  localparam logic [SAMPLE_W-1:0] SILENCE_LEVEL = 12'd2047;

  // x / 3 == (x * 43691) >> 17 for every x below 2^17
  localparam logic [16:0] DIV3_MUL   = 17'd43691;
  localparam int unsigned DIV3_SHIFT = 17;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // APB register map, index = paddr[4:2]
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [2:0] REG_SPS   = 3'd0;
  localparam logic [2:0] REG_PAT0  = 3'd1;
  localparam logic [2:0] REG_PAT1  = 3'd2;
  localparam logic [2:0] REG_PAT2  = 3'd3;
  localparam logic [2:0] REG_LEN0  = 3'd4;
  localparam logic [2:0] REG_LEN1  = 3'd5;
  localparam logic [2:0] REG_LEN2  = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_SUM,
    ST_MIX
  } dsm_state_e;

  typedef struct packed {
    logic [TICK_W-1:0]                    sps;
    logic [VOICE_COUNT-1:0][STEP_COUNT-1:0] pattern;
    logic [VOICE_COUNT-1:0][LEN_W-1:0]    length;
  } dsm_cfg_t;

  typedef struct packed {
    logic load_wr;   // store the accepted load item
    logic step_en;   // advance sequencer, issue sample reads
    logic sum_en;    // add up read data
    logic out_load;  // write result into output register
  } dsm_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } dsm_sts_t;

endpackage

FILE: hdl/dsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsm_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/dsm_regs.sv
// APB configuration registers of the drum sequencer.
// Depends on dsm_pkg.
module dsm_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dsm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dsm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dsm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output dsm_pkg::dsm_cfg_t              cfg_o
);

  // tempo 1, patterns and lengths cleared
  localparam dsm_pkg::dsm_cfg_t CFG_RESET = '{sps: 16'd1, pattern: '0, length: '0};

  dsm_pkg::dsm_cfg_t cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        dsm_pkg::REG_SPS:  cfg_d.sps        = pwdata[15:0];
        dsm_pkg::REG_PAT0: cfg_d.pattern[0] = pwdata[15:0];
        dsm_pkg::REG_PAT1: cfg_d.pattern[1] = pwdata[15:0];
        dsm_pkg::REG_PAT2: cfg_d.pattern[2] = pwdata[15:0];
        dsm_pkg::REG_LEN0: cfg_d.length[0]  = pwdata[13:0];
        dsm_pkg::REG_LEN1: cfg_d.length[1]  = pwdata[13:0];
        dsm_pkg::REG_LEN2: cfg_d.length[2]  = pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      dsm_pkg::REG_SPS:  prdata = {16'd0, cfg_q.sps};
      dsm_pkg::REG_PAT0: prdata = {16'd0, cfg_q.pattern[0]};
      dsm_pkg::REG_PAT1: prdata = {16'd0, cfg_q.pattern[1]};
      dsm_pkg::REG_PAT2: prdata = {16'd0, cfg_q.pattern[2]};
      dsm_pkg::REG_LEN0: prdata = {18'd0, cfg_q.length[0]};
      dsm_pkg::REG_LEN1: prdata = {18'd0, cfg_q.length[1]};
      dsm_pkg::REG_LEN2: prdata = {18'd0, cfg_q.length[2]};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/dsm_ctrl.sv
// Controller of the drum sequencer: sequences a tick through step, sum, mix.
// Depends on dsm_pkg.
module dsm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  input  dsm_pkg::dsm_sts_t sts_i,
  output dsm_pkg::dsm_cmd_t cmd_o
);

  dsm_pkg::dsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dsm_pkg::ST_IDLE: begin
        // ready is high here, so valid alone means an accepted item
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == dsm_pkg::OP_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            state_d = dsm_pkg::ST_STEP;
          end
        end
      end
      dsm_pkg::ST_STEP: begin
        cmd_o.step_en = 1'b1;
        state_d       = dsm_pkg::ST_SUM;
      end
      dsm_pkg::ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = dsm_pkg::ST_MIX;
      end
      dsm_pkg::ST_MIX: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = dsm_pkg::ST_IDLE;
        end
      end
      default: state_d = dsm_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/dsm_datapath.sv
// Datapath of the drum sequencer: step counter, voice state, sample RAMs,
// mixer with divide by active count, output register. Depends on dsm_pkg, dsm_ram.
module dsm_datapath #(
  parameter int unsigned SAMPLE_DEPTH = dsm_pkg::SAMPLE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dsm_pkg::dsm_cfg_t               cfg_i,
  input  dsm_pkg::dsm_cmd_t               cmd_i,
  output dsm_pkg::dsm_sts_t               sts_o,
  input  logic [dsm_pkg::VOICE_W-1:0]     ld_voice_i,
  input  logic [dsm_pkg::ADDR_IN_W-1:0]   ld_addr_i,
  input  logic [dsm_pkg::SAMPLE_W-1:0]    ld_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dsm_pkg::SAMPLE_W-1:0]    out_sample_o,
  output logic [dsm_pkg::STEP_W-1:0]      out_beat_o
);

  localparam int unsigned AW    = $clog2(SAMPLE_DEPTH);
  localparam int unsigned DW    = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned CMP_W = (DW > dsm_pkg::LEN_W) ? DW : dsm_pkg::LEN_W;
  localparam int unsigned VC    = dsm_pkg::VOICE_COUNT;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(SAMPLE_DEPTH);

  // sequencer state
  logic [dsm_pkg::TICK_W-1:0] tick_q, tick_d, tick_inc;
  logic [dsm_pkg::STEP_W-1:0] step_q, step_d, beat_q;
  logic                       adv;
  logic [VC-1:0]              active_q, active_d, trig, hit, mask_q;
  logic [VC-1:0][dsm_pkg::LEN_W-1:0] pos_q, pos_d, pos_cur;
  logic [VC-1:0][CMP_W-1:0]   usable;
  logic [VC-1:0][AW-1:0]      rd_addr;
  logic [VC-1:0][dsm_pkg::SAMPLE_W-1:0] rd_data;

  // mixer
  logic [dsm_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [dsm_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [30:0]                prod3;
  logic [dsm_pkg::SUM_W-1:0]  quot;
  logic [dsm_pkg::SAMPLE_W-1:0] mixed;

  // output register
  logic                         out_valid_q;
  logic [dsm_pkg::SAMPLE_W-1:0] out_sample_q;
  logic [dsm_pkg::STEP_W-1:0]   out_beat_q;

  // load path
  logic          ld_ok;
  logic [VC-1:0] we;

  assign ld_ok = cmd_i.load_wr
               && ({{(CMP_W-dsm_pkg::ADDR_IN_W){1'b0}}, ld_addr_i} < DEPTH_C);

  for (genvar v = 0; v < VC; v++) begin : g_voice
    assign we[v]      = ld_ok && (ld_voice_i == dsm_pkg::VOICE_W'(v));
    assign usable[v]  = (CMP_W'(cfg_i.length[v]) > DEPTH_C) ? DEPTH_C
                                                            : CMP_W'(cfg_i.length[v]);
    assign trig[v]    = adv & cfg_i.pattern[v][~step_d];
    assign pos_cur[v] = trig[v] ? '0 : pos_q[v];
    assign hit[v]     = (active_q[v] | trig[v]) && (CMP_W'(pos_cur[v]) < usable[v]);
    assign rd_addr[v] = AW'(pos_cur[v]);
    assign active_d[v] = hit[v];
    assign pos_d[v]    = hit[v] ? pos_cur[v] + 1'b1 : pos_cur[v];

    dsm_ram #(
      .WIDTH (dsm_pkg::SAMPLE_W),
      .DEPTH (SAMPLE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[v]),
      .waddr_i (AW'(ld_addr_i)),
      .wdata_i (ld_value_i),
      .re_i    (cmd_i.step_en),
      .raddr_i (rd_addr[v]),
      .rdata_o (rd_data[v])
    );
  end

  // tick counter and step index; a zero tempo advances on every tick
  assign tick_inc = tick_q + 1'b1;
  assign adv      = tick_inc >= cfg_i.sps;
  assign tick_d   = adv ? '0 : tick_inc;
  assign step_d   = adv ? step_q + 1'b1 : step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      step_q   <= '0;
      active_q <= '0;
      pos_q    <= '0;
    end else if (cmd_i.step_en) begin
      tick_q   <= tick_d;
      step_q   <= step_d;
      active_q <= active_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_en) begin
      mask_q <= hit;
      beat_q <= ~step_d;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < VC; i++) begin
      if (mask_q[i]) begin
        sum_d = sum_d + dsm_pkg::SUM_W'(rd_data[i]);
      end
    end
  end
  assign cnt_d = dsm_pkg::CNT_W'($countones(mask_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign prod3 = 31'(sum_q) * 31'(dsm_pkg::DIV3_MUL);

  always_comb begin
    case (cnt_q)
      2'd1:    quot = sum_q;
      2'd2:    quot = sum_q >> 1;
      2'd3:    quot = prod3[dsm_pkg::DIV3_SHIFT +: dsm_pkg::SUM_W];
      default: quot = '0;
    endcase
    if (cnt_q == 2'd0) begin
      mixed = dsm_pkg::SILENCE_LEVEL;
    end else if (quot > dsm_pkg::SUM_W'(dsm_pkg::FULL_SCALE)) begin
      mixed = dsm_pkg::FULL_SCALE;
    end else begin
      mixed = quot[dsm_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_sample_q <= mixed;
      out_beat_q   <= beat_q;
    end
  end

  assign sts_o.out_free = !out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_sample_o   = out_sample_q;
  assign out_beat_o     = out_beat_q;

endmodule

FILE: hdl/drum_step_sequencer_mixer.sv
// Drum step sequencer mixer, top level. Load item: written to RAM at accept, the input
// stays ready. Tick item: accept, step, sum, mix; the result is written into the output
// register in mix, and no new item is taken until the tick has returned to idle; mix
// waits while the output register is stalled. The registered sample RAM read lies between
// step and sum. Reset (rst_ni, async, low): controller, sequencer and voice state cleared,
// tempo 1, patterns/lengths 0; sample RAM kept.
`include "assert_macros.svh"

module drum_step_sequencer_mixer #(
  parameter int unsigned SAMPLE_DEPTH = dsm_pkg::SAMPLE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // voice[1:0], address[14:2], value[26:15]
  input  logic                           s_axis_tuser,  // operation: 0 tick, 1 load
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // sample[11:0], beat[15:12]
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dsm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dsm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dsm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  dsm_pkg::dsm_cfg_t cfg;
  dsm_pkg::dsm_cmd_t cmd;
  dsm_pkg::dsm_sts_t sts;

  logic [dsm_pkg::SAMPLE_W-1:0] out_sample;
  logic [dsm_pkg::STEP_W-1:0]   out_beat;

  // register file; the user must write it only while idle, the block does not enforce this
  dsm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // state machine: idle takes items, a tick walks step -> sum -> mix
  dsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counters, voice state, one RAM per voice, mixer, output register
  dsm_datapath #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .ld_voice_i   (s_axis_tdata[1:0]),
    .ld_addr_i    (s_axis_tdata[14:2]),
    .ld_value_i   (s_axis_tdata[26:15]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample),
    .out_beat_o   (out_beat)
  );

  assign m_axis_tdata = {out_beat, out_sample};

  // a tick keeps the input closed while it is worked on
  `ASSERT_PROP(a_tick_busy, clk_i, rst_ni,
               (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> !s_axis_tready,
               "input taken while a tick is in flight")
  // a load finishes in its accept cycle
  `ASSERT_PROP(a_load_quick, clk_i, rst_ni,
               (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> s_axis_tready,
               "load held the input closed")
  // a result is only written when the output register has room
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
                cmd.out_load && m_axis_tvalid && !m_axis_tready,
                "result overwrote a pending output item")
  // a written result shows up as valid
  `ASSERT_PROP(a_out_shown, clk_i, rst_ni,
               cmd.out_load |=> m_axis_tvalid,
               "result written but not presented")

endmodule
